// File: src/stack_machine_word_executor_top_assert.svh
// Assertion macros for the stack word executor.
`ifndef STACK_MACHINE_WORD_EXECUTOR_TOP_ASSERT_SVH
`define STACK_MACHINE_WORD_EXECUTOR_TOP_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk and held off during reset.
`define SMW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define SMW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SMW_ASSERT_IMP(lbl, ante, cons)
`define SMW_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: src/smw_pkg.sv
// Types, codes and constants of the stack word executor.
package smw_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 64;

  typedef enum logic [4:0] {
    OP_PUSH = 5'd0, OP_DUP = 5'd1, OP_SWAP = 5'd2, OP_DROP = 5'd3,
    OP_CLEAR = 5'd4, OP_OVER = 5'd5, OP_ROT = 5'd6, OP_COUNT = 5'd7,
    OP_PRINT = 5'd8, OP_ADD = 5'd9, OP_SUB = 5'd10, OP_MUL = 5'd11,
    OP_DIV = 5'd12, OP_MOD = 5'd13, OP_SQRT = 5'd14, OP_SUMALL = 5'd15,
    OP_MULALL = 5'd16, OP_EQ = 5'd17, OP_NEQ = 5'd18, OP_LT = 5'd19,
    OP_LTEQ = 5'd20, OP_GT = 5'd21, OP_GTEQ = 5'd22, OP_PICK_BOT = 5'd23,
    OP_PICK_TOP = 5'd24
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_FEW = 3'd1, ST_OVF = 3'd2, ST_IDX = 3'd3,
    ST_DIV0 = 3'd4, ST_NSQRT = 3'd5
  } status_t;

  typedef struct packed {
    logic [4:0]         opcode;
    logic signed [31:0] literal;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] top_value;
    logic signed [31:0] printed_value;
    logic               printed_valid;
    logic [6:0]         item_count;
  } out_item_t;

  // Items a word needs on the stack.
  function automatic logic [1:0] op_need(logic [4:0] op);
    logic [1:0] n;
    n = 2'd0;
    unique case (op)
      OP_DUP, OP_DROP, OP_PRINT, OP_SQRT, OP_SUMALL, OP_MULALL: n = 2'd1;
      OP_ROT: n = 2'd3;
      OP_SWAP, OP_OVER, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_NEQ,
      OP_LT, OP_LTEQ, OP_GT, OP_GTEQ, OP_PICK_BOT, OP_PICK_TOP: n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  // Words that grow the stack by one.
  function automatic logic op_grows(logic [4:0] op);
    return (op == OP_PUSH) || (op == OP_DUP) || (op == OP_OVER) || (op == OP_COUNT);
  endfunction

endpackage

// File: src/stack_machine_word_executor_top.sv
// Top level of the stack word executor: sequencer, stack memory and shared ALU.
// The top three items are read, the word executes, then up to three stack writes
// and the result strobe follow; div/mod add a divide loop, sqrt a root loop, the
// picks a read and capture, sum-all or product-all a read and accumulate per item
// below the top. Words are taken only in idle; busy stays high from acceptance
// through the result strobe; the receiver cannot stall. Synchronous reset empties the stack.
`include "stack_machine_word_executor_top_assert.svh"
module stack_machine_word_executor_top
  import smw_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_RDA    = 14'b00000000000010,
    S_RDB    = 14'b00000000000100,
    S_RDC    = 14'b00000000001000,
    S_CAP    = 14'b00000000010000,
    S_EXEC   = 14'b00000000100000,
    S_DIV    = 14'b00000001000000,
    S_SQRT   = 14'b00000010000000,
    S_RED_RD = 14'b00000100000000,
    S_RED_AC = 14'b00001000000000,
    S_PK_RD  = 14'b00010000000000,
    S_PK_CAP = 14'b00100000000000,
    S_WR     = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_t;

  state_t        state_r;
  logic [CW-1:0] cnt_r;
  logic [4:0]    op_r;
  logic [31:0]   lit_r, a_r, b_r, c_r, top_r, printed_r, acc_r, mb_r;
  logic [31:0]   rem_r, quo_r, bit_r;
  logic          pvalid_r;
  status_t       status_r;
  logic [4:0]    iter_r;
  logic [AW-1:0] ptr_r, pk_idx_r;
  logic [AW-1:0] w_addr_r [3];
  logic [31:0]   w_data_r [3];
  logic [1:0]    w_idx_r, w_last_r;

  logic [31:0]   mem [STACK_DEPTH];
  logic [31:0]   rdata_r;
  logic [AW-1:0] raddr;

  logic [CW-1:0] cnt_m1, cnt_m2, cnt_m3, pk_top;
  logic [31:0]   cnt32, mul_x, mul_y, mul_p, add_p;
  logic [32:0]   div_sh, div_dif;
  logic [31:0]   div_rem, div_quo, sq_t, sq_v, sq_res;
  logic          sq_ge;

  assign cnt_m1 = cnt_r - CW'(1);
  assign cnt_m2 = cnt_r - CW'(2);
  assign cnt_m3 = cnt_r - CW'(3);
  assign pk_top = cnt_m2 - a_r[CW-1:0];
  assign cnt32  = 32'(cnt_r);

  // Shared multiplier and adder: reduction walk or top pair
  assign mul_x = (state_r == S_RED_AC) ? acc_r : a_r;
  assign mul_y = (state_r == S_RED_AC) ? rdata_r : b_r;
  assign mul_p = mul_x * mul_y;
  assign add_p = mul_x + mul_y;

  // Restoring divide step
  assign div_sh  = {rem_r, quo_r[31]};
  assign div_dif = div_sh - {1'b0, mb_r};
  assign div_rem = div_dif[32] ? div_sh[31:0] : div_dif[31:0];
  assign div_quo = {quo_r[30:0], ~div_dif[32]};

  // Square root step
  assign sq_t   = quo_r + bit_r;
  assign sq_ge  = rem_r >= sq_t;
  assign sq_v   = sq_ge ? (rem_r - sq_t) : rem_r;
  assign sq_res = sq_ge ? ((quo_r >> 1) + bit_r) : (quo_r >> 1);

  // Select the read address for the current step
  always_comb begin
    raddr = cnt_m1[AW-1:0];
    if (state_r == S_RDB) raddr = cnt_m2[AW-1:0];
    if (state_r == S_RDC) raddr = cnt_m3[AW-1:0];
    if (state_r == S_RED_RD) raddr = ptr_r;
    if (state_r == S_PK_RD) raddr = pk_idx_r;
  end

  // Stack memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (state_r == S_WR) mem[w_addr_r[w_idx_r]] <= w_data_r[w_idx_r];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r    <= in_data.opcode;
            lit_r   <= in_data.literal;
            state_r <= S_RDA;
          end
        end
        S_RDA: state_r <= S_RDB;
        S_RDB: begin
          a_r     <= rdata_r;
          state_r <= S_RDC;
        end
        S_RDC: begin
          b_r     <= rdata_r;
          state_r <= S_CAP;
        end
        S_CAP: begin
          c_r     <= rdata_r;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          status_r  <= ST_OK;
          printed_r <= '0;
          pvalid_r  <= 1'b0;
          w_idx_r   <= '0;
          w_last_r  <= '0;
          state_r   <= S_DONE;
          if (cnt_r < CW'(op_need(op_r))) begin
            status_r <= ST_FEW;
          end else if (op_grows(op_r) && cnt_r >= CW'(STACK_DEPTH)) begin
            status_r <= ST_OVF;
          end else begin
            unique case (op_r)
              OP_PUSH, OP_DUP, OP_OVER, OP_COUNT: begin
                w_addr_r[0] <= cnt_r[AW-1:0];
                if (op_r == OP_PUSH) w_data_r[0] <= lit_r;
                else if (op_r == OP_DUP) w_data_r[0] <= a_r;
                else if (op_r == OP_OVER) w_data_r[0] <= b_r;
                else w_data_r[0] <= cnt32;
                if (op_r == OP_PUSH) top_r <= lit_r;
                else if (op_r == OP_DUP) top_r <= a_r;
                else if (op_r == OP_OVER) top_r <= b_r;
                else top_r <= cnt32;
                cnt_r   <= cnt_r + CW'(1);
                state_r <= S_WR;
              end
              OP_SWAP: begin
                w_addr_r[0] <= cnt_m1[AW-1:0];
                w_data_r[0] <= b_r;
                w_addr_r[1] <= cnt_m2[AW-1:0];
                w_data_r[1] <= a_r;
                w_last_r    <= 2'd1;
                top_r       <= b_r;
                state_r     <= S_WR;
              end
              OP_DROP: begin
                cnt_r <= cnt_m1;
                top_r <= b_r;
              end
              OP_CLEAR: cnt_r <= '0;
              OP_ROT: begin
                w_addr_r[0] <= cnt_m3[AW-1:0];
                w_data_r[0] <= b_r;
                w_addr_r[1] <= cnt_m2[AW-1:0];
                w_data_r[1] <= a_r;
                w_addr_r[2] <= cnt_m1[AW-1:0];
                w_data_r[2] <= c_r;
                w_last_r    <= 2'd2;
                top_r       <= c_r;
                state_r     <= S_WR;
              end
              OP_PRINT: begin
                cnt_r     <= cnt_m1;
                top_r     <= b_r;
                printed_r <= a_r;
                pvalid_r  <= 1'b1;
              end
              OP_ADD, OP_SUB, OP_MUL, OP_EQ, OP_NEQ, OP_LT, OP_LTEQ, OP_GT,
              OP_GTEQ: begin
                logic [31:0] r;
                r = '0;
                if (op_r == OP_ADD) r = add_p;
                else if (op_r == OP_SUB) r = a_r - b_r;
                else if (op_r == OP_MUL) r = mul_p;
                else if (op_r == OP_EQ) r = {31'd0, a_r == b_r};
                else if (op_r == OP_NEQ) r = {31'd0, a_r != b_r};
                else if (op_r == OP_LT) r = {31'd0, $signed(a_r) < $signed(b_r)};
                else if (op_r == OP_LTEQ) r = {31'd0, $signed(a_r) <= $signed(b_r)};
                else if (op_r == OP_GT) r = {31'd0, $signed(a_r) > $signed(b_r)};
                else r = {31'd0, $signed(a_r) >= $signed(b_r)};
                w_addr_r[0] <= cnt_m2[AW-1:0];
                w_data_r[0] <= r;
                top_r       <= r;
                cnt_r       <= cnt_m1;
                state_r     <= S_WR;
              end
              OP_DIV, OP_MOD: begin
                if (b_r == '0) begin
                  status_r <= ST_DIV0;
                end else begin
                  rem_r   <= '0;
                  quo_r   <= a_r[31] ? (32'd0 - a_r) : a_r;
                  mb_r    <= b_r[31] ? (32'd0 - b_r) : b_r;
                  iter_r  <= 5'd31;
                  state_r <= S_DIV;
                end
              end
              OP_SQRT: begin
                if (a_r[31]) begin
                  status_r <= ST_NSQRT;
                end else begin
                  rem_r   <= a_r;
                  quo_r   <= '0;
                  bit_r   <= 32'h4000_0000;
                  iter_r  <= 5'd15;
                  state_r <= S_SQRT;
                end
              end
              OP_SUMALL, OP_MULALL: begin
                acc_r <= a_r;
                ptr_r <= cnt_m2[AW-1:0];
                if (cnt_r == CW'(1)) begin
                  w_addr_r[0] <= '0;
                  w_data_r[0] <= a_r;
                  top_r       <= a_r;
                  state_r     <= S_WR;
                end else begin
                  state_r <= S_RED_RD;
                end
              end
              OP_PICK_BOT, OP_PICK_TOP: begin
                if (a_r[31] || (a_r >= 32'(cnt_m1))) begin
                  status_r <= ST_IDX;
                  cnt_r    <= cnt_m1;
                  top_r    <= b_r;
                end else begin
                  pk_idx_r <= (op_r == OP_PICK_BOT) ? a_r[AW-1:0] : pk_top[AW-1:0];
                  state_r  <= S_PK_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          rem_r  <= div_rem;
          quo_r  <= div_quo;
          iter_r <= iter_r - 5'd1;
          if (iter_r == 5'd0) begin
            logic [31:0] r;
            if (op_r == OP_DIV) r = (a_r[31] != b_r[31]) ? (32'd0 - div_quo) : div_quo;
            else r = a_r[31] ? (32'd0 - div_rem) : div_rem;
            w_addr_r[0] <= cnt_m2[AW-1:0];
            w_data_r[0] <= r;
            top_r       <= r;
            cnt_r       <= cnt_m1;
            state_r     <= S_WR;
          end
        end
        S_SQRT: begin
          rem_r  <= sq_v;
          quo_r  <= sq_res;
          bit_r  <= bit_r >> 2;
          iter_r <= iter_r - 5'd1;
          if (iter_r == 5'd0) begin
            w_addr_r[0] <= cnt_m1[AW-1:0];
            w_data_r[0] <= sq_res;
            top_r       <= sq_res;
            state_r     <= S_WR;
          end
        end
        S_RED_RD: state_r <= S_RED_AC;
        S_RED_AC: begin
          logic [31:0] acc;
          acc   = (op_r == OP_SUMALL) ? add_p : mul_p;
          acc_r <= acc;
          ptr_r <= ptr_r - AW'(1);
          if (ptr_r == '0) begin
            w_addr_r[0] <= '0;
            w_data_r[0] <= acc;
            top_r       <= acc;
            cnt_r       <= CW'(1);
            state_r     <= S_WR;
          end else begin
            state_r <= S_RED_RD;
          end
        end
        S_PK_RD: state_r <= S_PK_CAP;
        S_PK_CAP: begin
          w_addr_r[0] <= cnt_m1[AW-1:0];
          w_data_r[0] <= rdata_r;
          top_r       <= rdata_r;
          state_r     <= S_WR;
        end
        S_WR: begin
          w_idx_r <= w_idx_r + 2'd1;
          if (w_idx_r == w_last_r) state_r <= S_DONE;
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Present the result transaction for one cycle
  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  always_comb begin
    out_data.status        = status_r;
    out_data.top_value     = (cnt_r != '0) ? top_r : '0;
    out_data.printed_value = printed_r;
    out_data.printed_valid = pvalid_r;
    out_data.item_count    = cnt32[6:0];
  end

  `SMW_ASSERT_NXT(a_strobe_single, out_valid, !out_valid)
  `SMW_ASSERT_NXT(a_accept_busy, start && !busy, busy && !out_valid)
  `SMW_ASSERT_IMP(a_count_bound, 1'b1, cnt_r <= CW'(STACK_DEPTH))
  `SMW_ASSERT_IMP(a_print_ok, out_valid && out_data.printed_valid, out_data.status == ST_OK)

endmodule
